@@ hw/rtl/eased_tween_timer_top_defines.svh @@
// Assertion macros shared by the eased tween timer RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef EASED_TWEEN_TIMER_TOP_DEFINES_SVH
`define EASED_TWEEN_TIMER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define ETT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ETT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ hw/rtl/ett_pkg.sv @@
// Shared types and constants for the eased tween timer.
// No dependencies.
package ett_pkg;

  localparam int TimeWidthDef = 32;
  localparam int FracBitsDef  = 16;
  localparam int DurW  = 24;
  localparam int ValW  = 32;
  localparam int ProgW = 18;
  localparam int DtW   = 16;
  localparam int ModeW = 3;
  localparam int IdxW  = 3;

  // Configuration register indexes
  localparam logic [IdxW-1:0] RegDuration = 3'd0;
  localparam logic [IdxW-1:0] RegDelay    = 3'd1;
  localparam logic [IdxW-1:0] RegMode     = 3'd2;
  localparam logic [IdxW-1:0] RegStart    = 3'd3;
  localparam logic [IdxW-1:0] RegEnd      = 3'd4;

  // Ease modes
  localparam logic [ModeW-1:0] ModeInCubic    = 3'd1;
  localparam logic [ModeW-1:0] ModeOutCubic   = 3'd2;
  localparam logic [ModeW-1:0] ModeInOutCubic = 3'd3;
  localparam logic [ModeW-1:0] ModeOutBack    = 3'd4;
  localparam logic [ModeW-1:0] ModeOutBounce  = 3'd5;

  // Command codes
  localparam logic CmdAdvance = 1'b0;
  localparam logic CmdStart   = 1'b1;

  // Multiplier operand select
  typedef enum logic [2:0] {
    MulTT  = 3'd0,   // acc = a*a >> F   (square of ease operand)
    MulPA  = 3'd1,   // acc = p*a >> F   (cube)
    MulC1  = 3'd2,   // acc = c1*sq >> F
    MulC2  = 3'd3,   // acc = (c1+1)*cube >> F
    MulVal = 3'd4    // not selected by the sequencer; the multiplier falls back to a*a
  } mul_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;      // latch item, update time, start setup
    logic     div_start;
    logic     div_step;
    logic     ease_prep; // set ease operand from quotient
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     save_sq;   // keep product as square
    logic     finish_ease;
    logic     out_load;
  } ett_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_busy;
    logic need_div;
  } ett_stat_t;

endpackage

@@ hw/rtl/ett_ctrl.sv @@
// Sequencer for the eased tween timer: steps divide, ease and lerp.
// Depends on ett_pkg and eased_tween_timer_top_defines.svh.
`include "eased_tween_timer_top_defines.svh"
module ett_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               out_busy,
  input  ett_pkg::ett_stat_t stat,
  output ett_pkg::ett_cmd_t  cmd
);

  typedef enum logic [8:0] {
    SIdle  = 9'b000000001,
    SSetup = 9'b000000010,
    SDiv   = 9'b000000100,
    SPrep  = 9'b000001000,
    SSq    = 9'b000010000,
    SCube  = 9'b000100000,
    SBack1 = 9'b001000000,
    SBack2 = 9'b010000000,
    SVal   = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   fin;

  assign in_stall = (state != SIdle);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.mul_sel = ett_pkg::MulTT;
    fin = 1'b0;
    case (state)
      SIdle: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = SSetup;
        end
      end
      SSetup: begin
        if (stat.need_div) begin
          cmd.div_start = 1'b1;
          state_next = SDiv;
        end else begin
          state_next = SVal;
        end
      end
      SDiv: begin
        cmd.div_step = 1'b1;
        if (!stat.div_busy) state_next = SPrep;
      end
      SPrep: begin
        cmd.ease_prep = 1'b1;
        state_next = SSq;
      end
      SSq: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = ett_pkg::MulTT;
        cmd.save_sq = 1'b1;
        state_next = SCube;
      end
      SCube: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = ett_pkg::MulPA;
        state_next = SBack1;
      end
      SBack1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = ett_pkg::MulC1;
        state_next = SBack2;
      end
      SBack2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = ett_pkg::MulC2;
        cmd.finish_ease = 1'b1;
        state_next = SVal;
      end
      SVal: begin
        fin = 1'b1;
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_next = SIdle;
        end
      end
      default: state_next = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= SIdle;
    else state <= state_next;
  end

  `ETT_ASSERT_IMP(a_onehot, clk, rst, 1'b1, $onehot(state), "state not one-hot")
  `ETT_ASSERT_NEXT(a_load_setup, clk, rst, cmd.load, state == SSetup, "load did not start")
  `ETT_ASSERT_IMP(a_out_only_val, clk, rst, cmd.out_load, fin, "result outside finish")

endmodule

@@ hw/rtl/ett_dp.sv @@
// Datapath: time state, config registers, divider, ease multiplier, lerp.
// Depends on ett_pkg.
module ett_dp #(
  parameter int TIME_WIDTH = ett_pkg::TimeWidthDef,
  parameter int FRAC_BITS  = ett_pkg::FracBitsDef
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [ett_pkg::IdxW-1:0]    cfg_index,
  input  logic [ett_pkg::ValW-1:0]    cfg_data,
  input  logic                        command,
  input  logic [ett_pkg::DtW-1:0]     dt,
  input  ett_pkg::ett_cmd_t           cmd,
  output ett_pkg::ett_stat_t          stat,
  output logic signed [ett_pkg::ProgW-1:0] progress,
  output logic signed [ett_pkg::ValW-1:0]  value,
  output logic                        animating
);

  localparam int F   = FRAC_BITS;
  localparam int QW  = F + 1;              // quotient 0..one
  localparam int NW  = ett_pkg::DurW + F + 1;
  localparam int EW  = F + 4;              // signed ease operand width
  localparam int PW  = 2 * EW;
  localparam int CntW = $clog2(NW + 1);
  localparam int TW  = TIME_WIDTH;
  localparam int SW  = (TW > ett_pkg::DurW ? TW : ett_pkg::DurW) + 1;
  localparam logic signed [EW-1:0] One = EW'(1) <<< F;
  localparam longint C1Q32 = 64'sd7308230452;
  localparam logic signed [EW-1:0] C1 =
    EW'((C1Q32 + (64'sd1 <<< (31 - F))) >>> (32 - F));

  // Configuration registers
  logic [ett_pkg::DurW-1:0]  dur, dly;
  logic [ett_pkg::ModeW-1:0] mode;
  logic signed [ett_pkg::ValW-1:0] sval, eval;
  always_ff @(posedge clk) begin
    if (rst) begin
      dur <= '0; dly <= '0; mode <= '0; sval <= '0; eval <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ett_pkg::RegDuration: dur  <= cfg_data[ett_pkg::DurW-1:0];
        ett_pkg::RegDelay:    dly  <= cfg_data[ett_pkg::DurW-1:0];
        ett_pkg::RegMode:     mode <= cfg_data[ett_pkg::ModeW-1:0];
        ett_pkg::RegStart:    sval <= cfg_data;
        ett_pkg::RegEnd:      eval <= cfg_data;
        default: ;
      endcase
    end
  end

  // Elapsed time and active flag
  logic [TW-1:0] elapsed;
  logic          active;
  logic [TW:0]   sum;
  logic [TW-1:0] el_next;
  logic [SW-1:0] target;
  assign sum = {1'b0, elapsed} + (TW+1)'(dt);
  assign el_next = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
  assign target = SW'(dly) + SW'(dur);
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0; active <= 1'b0;
    end else if (cmd.load) begin
      if (command == ett_pkg::CmdStart) begin
        elapsed <= '0;
        active <= (dur != '0);
      end else begin
        elapsed <= el_next;
        active <= !(SW'(el_next) >= target);
      end
    end
  end

  // Setup: classify and form local time
  logic [SW-1:0] loc;
  logic [ett_pkg::DurW-1:0] loc_c;
  logic zero_dur, pre_delay;
  assign zero_dur = (dur == '0);
  assign pre_delay = (SW'(elapsed) <= SW'(dly));
  assign loc = SW'(elapsed) - SW'(dly);
  assign loc_c = (loc > SW'(dur)) ? dur : loc[ett_pkg::DurW-1:0];
  assign stat.need_div = !zero_dur && !pre_delay;

  // Restoring divider, one quotient bit per cycle
  logic [NW-1:0] num;
  logic [ett_pkg::DurW:0] rem;
  logic [QW-1:0] quo;
  logic [CntW-1:0] cnt;
  logic [ett_pkg::DurW+1:0] trial;
  assign trial = {rem, num[NW-1]} - {2'b0, dur};
  assign stat.div_busy = (cnt != '0);
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_start) begin
      num <= NW'(loc_c) << F;
      rem <= '0;
      cnt <= CntW'(NW);
    end else if (cmd.div_step && cnt != '0) begin
      num <= num << 1;
      if (!trial[ett_pkg::DurW+1]) begin
        rem <= trial[ett_pkg::DurW:0];
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        rem <= {rem[ett_pkg::DurW-1:0], num[NW-1]};
        quo <= {quo[QW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
    end
  end

  // Ease operand a: cube argument per mode
  logic signed [EW-1:0] t, a, sq, cube, bk1, p;
  logic signed [PW-1:0] prod;
  logic signed [EW-1:0] ma, mb;
  logic signed [EW-1:0] ease;
  logic signed [EW-1:0] pr;

  always_ff @(posedge clk) begin
    if (cmd.ease_prep) begin
      t <= EW'(quo);
      case (mode)
        ett_pkg::ModeOutCubic, ett_pkg::ModeOutBack: a <= One - EW'(quo);
        ett_pkg::ModeInOutCubic:
          a <= (EW'(quo) <<< 1) < One ? EW'(quo) : (One <<< 1) - (EW'(quo) <<< 1);
        default: a <= EW'(quo);
      endcase
    end
  end

  // Shared multiplier, truncating to F
  always_comb begin
    case (cmd.mul_sel)
      ett_pkg::MulTT: begin ma = a;  mb = a;  end
      ett_pkg::MulPA: begin ma = p;  mb = a;  end
      ett_pkg::MulC1: begin ma = C1; mb = sq; end
      ett_pkg::MulC2: begin ma = C1 + One; mb = cube; end
      default:        begin ma = a;  mb = a;  end
    endcase
    prod = PW'(ma) * PW'(mb);
  end
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p <= EW'(prod >>> F);
      if (cmd.save_sq) sq <= EW'(prod >>> F);
      if (cmd.mul_sel == ett_pkg::MulPA) cube <= EW'(prod >>> F);
      if (cmd.mul_sel == ett_pkg::MulC1) bk1 <= EW'(prod >>> F);
    end
  end

  // Bounce, computed from t with a small constant multiply and a square
  localparam int BW = F + 8;
  logic signed [BW-1:0] t11, d;
  logic signed [2*BW-1:0] dd;
  logic signed [EW-1:0] bounce;
  localparam logic signed [BW-1:0] K4  = BW'(4) <<< F;
  localparam logic signed [BW-1:0] K6  = BW'(6) <<< F;
  localparam logic signed [BW-1:0] K8  = BW'(8) <<< F;
  localparam logic signed [BW-1:0] K9  = BW'(9) <<< F;
  localparam logic signed [BW-1:0] K10 = BW'(10) <<< F;
  localparam logic signed [BW-1:0] K21 = BW'(21) <<< F;
  // Segment offsets 3/4, 15/16 and 63/64 of one
  localparam logic signed [2*BW-1:0] Off3  = (2*BW)'(3) <<< (F - 2);
  localparam logic signed [2*BW-1:0] Off15 = (2*BW)'(15) <<< (F - 4);
  localparam logic signed [2*BW-1:0] Off63 = (2*BW)'(63) <<< (F - 6);
  always_comb begin
    t11 = BW'(t) * BW'(11);
    if (t11 < K4) d = t11;
    else if (t11 < K8) d = t11 - K6;
    else if (t11 < K10) d = t11 - K9;
    else d = (t11 <<< 1) - K21;
    dd = (2*BW)'(d) * (2*BW)'(d);
    if (t11 < K4) bounce = EW'(dd >>> (F + 4));
    else if (t11 < K8) bounce = EW'((dd >>> (F + 4)) + Off3);
    else if (t11 < K10) bounce = EW'((dd >>> (F + 4)) + Off15);
    else bounce = EW'((dd >>> (F + 6)) + Off63);
  end

  // Final ease select (cube held in 'cube', MulC2 product in prod this cycle)
  logic signed [EW-1:0] c2m3, raw;
  assign c2m3 = EW'(prod >>> F);
  always_comb begin
    case (mode)
      ett_pkg::ModeInCubic:    raw = cube;
      ett_pkg::ModeOutCubic:   raw = One - cube;
      ett_pkg::ModeInOutCubic:
        raw = ((t <<< 1) < One) ? (cube <<< 2) : One - (cube >>> 1);
      ett_pkg::ModeOutBack:    raw = One + bk1 - c2m3;
      ett_pkg::ModeOutBounce:  raw = bounce;
      default:                 raw = t;
    endcase
    ease = raw < 0 ? '0 : raw;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) pr <= '0;
    else if (cmd.finish_ease) pr <= ease;
  end

  // Progress select and lerp
  logic signed [EW-1:0] pf;
  logic signed [ett_pkg::ValW:0] diff;
  logic signed [ett_pkg::ValW+EW:0] vp, vq;
  logic signed [ett_pkg::ValW+EW+1:0] vs;
  assign pf = zero_dur ? One : (pre_delay ? '0 : pr);
  assign diff = (ett_pkg::ValW+1)'(eval) - (ett_pkg::ValW+1)'(sval);
  assign vp = (ett_pkg::ValW+EW+1)'(diff) * (ett_pkg::ValW+EW+1)'(pf);
  assign vq = (vp < 0) ? -((-vp) >>> F) : (vp >>> F);
  assign vs = (ett_pkg::ValW+EW+2)'(sval) + (ett_pkg::ValW+EW+2)'(vq);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (vs > (ett_pkg::ValW+EW+2)'(32'sh7fffffff)) value <= 32'sh7fffffff;
      else if (vs < -(ett_pkg::ValW+EW+2)'(33'sh80000000)) value <= 32'sh80000000;
      else value <= vs[ett_pkg::ValW-1:0];
      if (F >= 16) progress <= ett_pkg::ProgW'(pf >>> (F >= 16 ? F - 16 : 0));
      else progress <= ett_pkg::ProgW'(pf <<< (F < 16 ? 16 - F : 0));
      animating <= active;
    end
  end

endmodule

@@ hw/rtl/eased_tween_timer_top.sv @@
// Eased tween timer.
// Channels: input items (command, dt) under in_valid/in_stall; results
// (progress, value, animating) under out_valid/out_stall. Both accept on
// a rising edge with valid high and stall low.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle; the
// user must write only while no item is in flight (not enforced by the block).
// Sequence: after acceptance an item passes setup, the divider producing one
// quotient bit a cycle over FRAC_BITS+25 steps, the ease operand, four shared
// multiplies and the lerp into the output register; one item at a time, so a
// new item waits until the sequencer has loaded the last result.
// Items taking the zero-duration or pre-delay path skip the divide and the
// multiplies, going from setup straight to the result.
// The result sits in an output register; a new item is accepted while it
// waits, and its result waits until the old one is taken.
// Reset (rst, synchronous) clears elapsed time, active flag, configuration registers and
// the output valid. A stalled receiver holds the result and the payload.
// Depends on ett_pkg, ett_ctrl, ett_dp.
module eased_tween_timer_top #(
  parameter int TIME_WIDTH = ett_pkg::TimeWidthDef,
  parameter int FRAC_BITS  = ett_pkg::FracBitsDef
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [ett_pkg::IdxW-1:0] cfg_index,
  input  logic [ett_pkg::ValW-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic command,
  input  logic [ett_pkg::DtW-1:0] dt,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [ett_pkg::ProgW-1:0] progress,
  output logic signed [ett_pkg::ValW-1:0]  value,
  output logic animating
);

  ett_pkg::ett_cmd_t  cmd;
  ett_pkg::ett_stat_t stat;
  logic out_busy;

  assign out_busy = out_valid && out_stall;

  ett_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_busy, .stat, .cmd
  );

  ett_dp #(.TIME_WIDTH(TIME_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .command, .dt,
    .cmd, .stat, .progress, .value, .animating
  );

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

endmodule
